@@ src/epm_pkg.sv @@
package epm_pkg;

    localparam int POOL_WORDS_DEF = 128;
    localparam int WORD_W         = 32;
    localparam int TAP_COUNT      = 6;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_cmd;

    // Tap offsets from the add pointer, the pointer slot itself last.
    function automatic logic [6:0] tap_offset(input logic [2:0] k);
        logic [6:0] ofs;
        case (k)
            3'd0:    ofs = 7'd104;
            3'd1:    ofs = 7'd76;
            3'd2:    ofs = 7'd51;
            3'd3:    ofs = 7'd25;
            3'd4:    ofs = 7'd1;
            default: ofs = 7'd0;
        endcase
        return ofs;
    endfunction

    function automatic logic [WORD_W-1:0] twist(input logic [2:0] sel);
        logic [WORD_W-1:0] t;
        case (sel)
            3'd0:    t = 32'h00000000;
            3'd1:    t = 32'h3b6e20c8;
            3'd2:    t = 32'h76dc4190;
            3'd3:    t = 32'h4db26158;
            3'd4:    t = 32'hedb88320;
            3'd5:    t = 32'hd6d6a3e8;
            3'd6:    t = 32'h9b64c2b0;
            default: t = 32'ha00ae278;
        endcase
        return t;
    endfunction

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] r);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << r;
        return d[2*WORD_W-1:WORD_W];
    endfunction

endpackage

@@ src/epm_pool_ram.sv @@
module epm_pool_ram
    import epm_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF,
    localparam int ADDR_W    = $clog2(POOL_WORDS)
) (
    input  logic              i_clk,
    input  t_ram_cmd          i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [POOL_WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/epm_seq.sv @@
module epm_seq
    import epm_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF,
    localparam int ADDR_W    = $clog2(POOL_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic              i_count_new,
    input  logic [6:0]        i_read_index,
    input  logic              i_end_of_batch,
    output t_ram_cmd          o_ram_cmd,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [WORD_W-1:0] o_ram_wdata,
    input  logic [WORD_W-1:0] i_ram_rdata,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_result_word,
    output logic [WORD_W-1:0] o_new_entropy_count,
    output logic              o_batch_done
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_TAP   = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;

    localparam logic [2:0] LAST_TAP = 3'(TAP_COUNT);

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_ptr;
    logic [4:0]        r_rot;
    logic [WORD_W-1:0] r_fresh;
    logic [WORD_W-1:0] r_acc;
    logic [2:0]        r_tap;
    logic              r_batch;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [WORD_W-1:0] r_out_count;
    logic              r_out_batch;

    logic              accept;
    logic [ADDR_W-1:0] n_ptr;
    logic [WORD_W-1:0] mix_out;
    logic              n_out_valid;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign n_ptr   = r_ptr - ADDR_W'(1);
    assign mix_out = (r_acc >> 3) ^ twist(r_acc[2:0]);

    // Clear and unused codes answer at once; adds and reads answer from their last state.
    assign n_out_valid = (r_state == S_WR) || (r_state == S_RDATA) ||
                         (accept && i_func != FUNC_ADD && i_func != FUNC_READ);

    always_comb begin
        o_ram_cmd   = '0;
        o_ram_addr  = '0;
        o_ram_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                o_ram_cmd.we = 1'b1;
                o_ram_addr   = r_clr_addr;
            end
            S_IDLE: begin
                if (accept && i_func == FUNC_READ) begin
                    o_ram_cmd.re = 1'b1;
                    o_ram_addr   = ADDR_W'(i_read_index);
                end
            end
            S_TAP: begin
                if (r_tap != LAST_TAP) begin
                    o_ram_cmd.re = 1'b1;
                    o_ram_addr   = r_ptr + ADDR_W'(tap_offset(r_tap));
                end
            end
            S_WR: begin
                o_ram_cmd.we = 1'b1;
                o_ram_addr   = r_ptr;
                o_ram_wdata  = mix_out;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_ptr       <= '0;
            r_rot       <= '0;
            r_fresh     <= '0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(POOL_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_batch <= i_end_of_batch;
                        case (i_func)
                            FUNC_ADD: begin
                                r_ptr   <= n_ptr;
                                r_rot   <= r_rot + ((n_ptr != '0) ? 5'd7 : 5'd14);
                                r_acc   <= rotl32(i_data_word, r_rot);
                                r_tap   <= '0;
                                r_state <= S_TAP;
                                if (i_count_new && r_fresh != '1) begin
                                    r_fresh <= r_fresh + WORD_W'(1);
                                end
                            end
                            FUNC_READ: begin
                                r_state <= S_RDATA;
                            end
                            FUNC_CLEAR: begin
                                r_fresh     <= '0;
                                r_out_word  <= '0;
                                r_out_count <= '0;
                                r_out_batch <= i_end_of_batch;
                            end
                            default: begin
                                r_out_word  <= '0;
                                r_out_count <= r_fresh;
                                r_out_batch <= i_end_of_batch;
                            end
                        endcase
                    end
                end
                S_TAP: begin
                    // Read data arrives the cycle after its address.
                    if (r_tap != '0) begin
                        r_acc <= r_acc ^ i_ram_rdata;
                    end
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == LAST_TAP) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_out_word  <= mix_out;
                    r_out_count <= r_fresh;
                    r_out_batch <= r_batch;
                    r_state     <= S_IDLE;
                end
                S_RDATA: begin
                    r_out_word  <= i_ram_rdata;
                    r_out_count <= r_fresh;
                    r_out_batch <= r_batch;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_result_word       = r_out_word;
    assign o_new_entropy_count = r_out_count;
    assign o_batch_done        = r_out_batch;

endmodule

@@ src/entropy_pool_mixer_unit.sv @@
// Add word: the result strobe follows states S_TAP and S_WR; busy is high through both.
// Read word: the strobe follows state S_RDATA; clear and unused codes: strobe next cycle.
// One word at a time; the add time is set by six pool reads and one write on the single port.
// Synchronous reset clears pointer, rotation and counter, then zeroes the pool one word
// per cycle, all POOL_WORDS words, with busy high. The receiver cannot stall results.
module entropy_pool_mixer_unit
    import epm_pkg::*;
#(
    parameter int POOL_WORDS = POOL_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_data_word,
    input  logic        i_count_new,
    input  logic [6:0]  i_read_index,
    input  logic        i_end_of_batch,
    output logic        o_valid,
    output logic [31:0] o_result_word,
    output logic [31:0] o_new_entropy_count,
    output logic        o_batch_done
);

    localparam int ADDR_W = $clog2(POOL_WORDS);

    t_ram_cmd          ram_cmd;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    epm_seq #(
        .POOL_WORDS(POOL_WORDS)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_func              (i_func),
        .i_data_word         (i_data_word),
        .i_count_new         (i_count_new),
        .i_read_index        (i_read_index),
        .i_end_of_batch      (i_end_of_batch),
        .o_ram_cmd           (ram_cmd),
        .o_ram_addr          (ram_addr),
        .o_ram_wdata         (ram_wdata),
        .i_ram_rdata         (ram_rdata),
        .o_valid             (o_valid),
        .o_result_word       (o_result_word),
        .o_new_entropy_count (o_new_entropy_count),
        .o_batch_done        (o_batch_done)
    );

    epm_pool_ram #(
        .POOL_WORDS(POOL_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_CLEAR) |=> (o_valid && o_new_entropy_count == '0))
        else $error("clear word did not report a zero count");

    a_add_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_ADD) |-> ##9 o_valid)
        else $error("add word result missing after nine cycles");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

endmodule
